### rtl/core/sm3_pkg.sv
// SM3 hash core package: initial value, round constants, command struct
// and the bit-level helper functions. Used by the controller, datapath and top.
// No dependencies.
package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumChain = 8;
  localparam int unsigned NumWin   = 16;
  localparam int unsigned NumRound = 64;

  localparam logic [WordW-1:0] SM3_IV [NumChain] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic [WordW-1:0] T_LOW  = 32'h79CC4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7A879D8A;

  // tuser bit positions on the slave side
  localparam int unsigned UserStartBit = 0;
  localparam int unsigned UserFinalBit = 1;
  localparam int unsigned UserW        = 2;

  typedef struct packed {
    logic       load_iv;
    logic       shift_in;
    logic       init_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       update_chain;
    logic [2:0] out_idx;
  } sm3_cmd_t;

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x,
                                              input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  // constant for round j, already rotated by j mod 32
  function automatic logic [WordW-1:0] round_const(input logic [5:0] j);
    logic [WordW-1:0] t;
    t = (j < 6'd16) ? T_LOW : T_HIGH;
    return rotl32(t, j[4:0]);
  endfunction

endpackage

### rtl/core/sm3_ctrl.sv
// SM3 controller: word collection count, final flag, round sequencing
// and digest emission. Drives the datapath through sm3_pkg::sm3_cmd_t.
module sm3_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              start_i,
  input  logic              final_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  input  logic              out_ready_i,
  output sm3_pkg::sm3_cmd_t cmd_o
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [3:0] count_q;
  logic       pend_q;
  logic       emit_fin_q;
  logic [5:0] round_q;
  logic [2:0] emit_q;

  logic in_acc;
  logic out_acc;
  logic complete;

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_last_o  = (emit_q == 3'd7);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  assign complete    = in_acc & ~start_i & (count_q == 4'd15);

  always_comb begin
    cmd_o              = '0;
    cmd_o.load_iv      = in_acc & start_i;
    cmd_o.shift_in     = in_acc;
    cmd_o.init_work    = complete;
    cmd_o.round_en     = (state_q == ST_ROUND);
    cmd_o.round_idx    = round_q;
    cmd_o.update_chain = (state_q == ST_UPDATE);
    cmd_o.out_idx      = emit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_COLLECT;
      count_q    <= '0;
      pend_q     <= 1'b0;
      emit_fin_q <= 1'b0;
      round_q    <= '0;
      emit_q     <= '0;
    end else begin
      unique case (state_q)
        ST_COLLECT: begin
          if (in_acc) begin
            if (complete) begin
              count_q    <= '0;
              pend_q     <= 1'b0;
              emit_fin_q <= pend_q | final_i;
              round_q    <= '0;
              state_q    <= ST_ROUND;
            end else if (start_i) begin
              count_q <= 4'd1;
              pend_q  <= final_i;
            end else begin
              count_q <= count_q + 4'd1;
              pend_q  <= pend_q | final_i;
            end
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'(NumRound - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          emit_q  <= '0;
          state_q <= emit_fin_q ? ST_EMIT : ST_COLLECT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_q <= emit_q + 3'd1;
            if (emit_q == 3'd7) begin
              state_q <= ST_COLLECT;
            end
          end
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

endmodule

### rtl/core/sm3_datapath.sv
// SM3 datapath: chaining value, 16-word message window with on-the-fly
// expansion, eight working registers and the round function. Uses sm3_pkg.
module sm3_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm3_pkg::sm3_cmd_t cmd_i,
  input  logic [31:0]       msg_word_i,
  output logic [31:0]       digest_word_o
);
  import sm3_pkg::*;

  logic [WordW-1:0] chain_q [NumChain];
  logic [WordW-1:0] win_q [NumWin];
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

  logic [WordW-1:0] w_new, win_in;
  logic [WordW-1:0] a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    w_new  = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 5'd15))
             ^ rotl32(win_q[3], 5'd7) ^ win_q[10];
    win_in = cmd_i.round_en ? w_new : msg_word_i;

    a12 = rotl32(a_q, 5'd12);
    ss1 = rotl32(a12 + e_q + round_const(cmd_i.round_idx), 5'd7);
    ss2 = ss1 ^ a12;
    if (cmd_i.round_idx < 6'd16) begin
      ff = a_q ^ b_q ^ c_q;
      gg = e_q ^ f_q ^ g_q;
    end else begin
      ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
      gg = (e_q & f_q) | (~e_q & g_q);
    end
    tt1 = ff + d_q + ss2 + (win_q[0] ^ win_q[4]);
    tt2 = gg + h_q + ss1 + win_q[0];
  end

  assign digest_word_o = chain_q[cmd_i.out_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= SM3_IV;
    end else if (cmd_i.load_iv) begin
      chain_q <= SM3_IV;
    end else if (cmd_i.update_chain) begin
      chain_q[0] <= chain_q[0] ^ a_q;
      chain_q[1] <= chain_q[1] ^ b_q;
      chain_q[2] <= chain_q[2] ^ c_q;
      chain_q[3] <= chain_q[3] ^ d_q;
      chain_q[4] <= chain_q[4] ^ e_q;
      chain_q[5] <= chain_q[5] ^ f_q;
      chain_q[6] <= chain_q[6] ^ g_q;
      chain_q[7] <= chain_q[7] ^ h_q;
    end
  end

  // window: entry 0 holds W[j]
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in || cmd_i.round_en) begin
      for (int i = 0; i < NumWin - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[NumWin-1] <= win_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_work) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
      f_q <= chain_q[5];
      g_q <= chain_q[6];
      h_q <= chain_q[7];
    end else if (cmd_i.round_en) begin
      d_q <= c_q;
      c_q <= rotl32(b_q, 5'd9);
      b_q <= a_q;
      a_q <= tt1;
      h_q <= g_q;
      g_q <= rotl32(f_q, 5'd19);
      f_q <= e_q;
      e_q <= perm0(tt2);
    end
  end

endmodule

### rtl/core/sm3_hash_core.sv
// SM3 hash core top: one 32-bit message word per request, 32-bit digest words out.
// Message words are taken while collecting; a full block then runs the 64 rounds (one round per
// cycle in the datapath) and one chaining update, and no new word is taken until they are done.
// A final block adds 8 digest words, emitted after its chaining update.
// Reset (async, active low) loads the SM3 initial value and clears the counts.
// Depends on sm3_pkg, sm3_ctrl and sm3_datapath.
module sm3_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] msg_word
  input  logic [1:0]  s_axis_tuser_i,   // [0] start_msg, [1] final_block
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o    // last_word
);
  import sm3_pkg::*;

  sm3_cmd_t cmd;

  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .start_i     (s_axis_tuser_i[UserStartBit]),
    .final_i     (s_axis_tuser_i[UserFinalBit]),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  sm3_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (s_axis_tdata_i),
    .digest_word_o (m_axis_tdata_o)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for sm3_hash_core: streams padded message words in and checks every digest word.
// A local SM3 predictor tracks the chaining value, block buffer and final flag per request.
// Depends on sm3_pkg (tuser bit positions) and the sm3_hash_core RTL.
module testbench;

  import sm3_pkg::*;

  localparam int unsigned NumWords   = 270;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned CycleLimit = 200000;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] T_EARLY = 32'h79CC4519;
  localparam logic [31:0] T_LATE  = 32'h7A879D8A;

  typedef struct packed {
    logic [31:0] word;
    logic        start;
    logic        fin;
  } msg_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic [1:0]  user_nxt;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  msg_req_t     req_q[$];
  digest_beat_t digest_q[$];
  msg_req_t     cur_req;
  digest_beat_t want;

  logic [31:0] chain_v [8] = IV_WORDS;
  logic [31:0] blk_buf [16];
  logic [3:0]  fill_idx = '0;
  logic        fin_seen = 1'b0;

  int unsigned n_queued   = 0;
  int unsigned n_starts   = 0;
  int unsigned words_acc  = 0;
  int unsigned blocks_run = 0;
  int unsigned beats_ok   = 0;
  int unsigned fails      = 0;
  int unsigned cycle_cnt  = 0;
  logic        calm;

  assign calm = (words_acc >= 120) && (words_acc < 200);

  sm3_hash_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] p0(logic [31:0] x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] p1(logic [31:0] x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

  function automatic void compress_chain();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk_buf[j];
    for (int j = 16; j < 68; j++)
      w[j] = p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
    a = chain_v[0]; b = chain_v[1]; c = chain_v[2]; d = chain_v[3];
    e = chain_v[4]; f = chain_v[5]; g = chain_v[6]; h = chain_v[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? T_EARLY : T_LATE;
      a12 = rol32(a, 12);
      ss1 = rol32(a12 + e + rol32(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol32(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol32(f, 19);
      f = e;
      e = p0(tt2);
    end
    chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
    chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
  endfunction

  // one accepted request; queues the digest when a final block completes
  function automatic void absorb_word(msg_req_t r);
    if (r.start) begin
      chain_v  = IV_WORDS;
      fill_idx = '0;
      fin_seen = 1'b0;
    end
    blk_buf[fill_idx] = r.word;
    if (r.fin) fin_seen = 1'b1;
    if (fill_idx != 4'd15) begin
      fill_idx = fill_idx + 4'd1;
    end else begin
      compress_chain();
      blocks_run++;
      fill_idx = '0;
      if (fin_seen) begin
        fin_seen = 1'b0;
        for (int k = 0; k < 8; k++) digest_q.push_back(digest_beat_t'{chain_v[k], k == 7});
      end
    end
  endfunction

  function automatic void add_word(logic [31:0] w, logic st, logic fin);
    req_q.push_back(msg_req_t'{w, st, fin});
    n_queued++;
    if (st) n_starts++;
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0000_0000;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        absorb_word(cur_req);
        words_acc++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          cur_req = req_q.pop_front();
          user_nxt = '0;
          user_nxt[UserStartBit] = cur_req.start;
          user_nxt[UserFinalBit] = cur_req.fin;
          s_valid <= 1'b1;
          s_data  <= cur_req.word;
          s_user  <= user_nxt;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h last %b", $time, m_axis_tdata_o,
                   m_axis_tlast_o);
          fails++;
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata_o !== want.word) begin
            $display("%0t: digest word mismatch exp %h got %h", $time, want.word,
                     m_axis_tdata_o);
            fails++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $display("%0t: tlast mismatch exp %b got %b", $time, want.last, m_axis_tlast_o);
            fails++;
          end
          beats_ok++;
        end
      end
      m_ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words outstanding", cycle_cnt,
               digest_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned kind, nblk, fmode, fpos, len;
    logic        st;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // partial block with a final flag, then dropped by a restart
    add_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_word(32'h0000_0000, 1'b0, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_word(32'h0000_0000, 1'b0, 1'b0);
    add_word(32'h8000_0000, 1'b0, 1'b0);
    // padded "abc", final flag on a single middle word only
    for (int i = 0; i < 16; i++)
      add_word((i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : 32'h0,
               i == 0, i == 9);

    while (req_q.size() != 0 || s_valid || digest_q.size() != 0) @(negedge clk_i);

    while (n_queued < NumWords) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        nblk  = ($urandom_range(3) == 0) ? 2 + $urandom_range(1) : 1;
        fmode = $urandom_range(2);
        fpos  = $urandom_range(15);
        for (int b = 0; b < nblk; b++)
          for (int i = 0; i < 16; i++)
            add_word(pick_word(), b == 0 && i == 0,
                     (b == nblk - 1) && (fmode == 0 || (fmode == 1 && i == 15) ||
                                         (fmode == 2 && i == fpos)));
      end else if (kind < 85) begin
        // keeps chaining from the previous value
        fpos = $urandom_range(15);
        for (int i = 0; i < 16; i++) add_word(pick_word(), 1'b0, i >= fpos);
      end else if (kind < 95) begin
        len = $urandom_range(15, 1);
        st  = 1'($urandom_range(1));
        for (int i = 0; i < len; i++)
          add_word(pick_word(), st && i == 0, $urandom_range(3) == 0);
      end else begin
        st = 1'($urandom_range(1));
        for (int i = 0; i < 16; i++) add_word(pick_word(), st && i == 0, 1'b0);
      end
    end

    while (req_q.size() != 0 || s_valid || digest_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d words in, %0d blocks compressed, %0d restarts, %0d digest words checked",
             words_acc, blocks_run, n_starts, beats_ok);
    $display("mix of single and multi-block messages, continuations, dropped partial blocks");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
